// ----- hw/rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define PAJ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define PAJ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/paj_pkg.sv -----
package paj_pkg;

    localparam int MaxNotes = 128;
    localparam int PitchW   = 7;
    localparam int CountW   = 8;

    localparam logic [1:0] CmdKey    = 2'd0;
    localparam logic [1:0] CmdReset  = 2'd1;
    localparam logic [1:0] CmdBuild  = 2'd2;
    localparam logic [1:0] CmdUnused = 2'd3;

    localparam logic [1:0] KindState   = 2'd1;
    localparam logic [1:0] KindNActive = 2'd2;

    localparam logic [6:0] CtlAllSoundOff = 7'd120;
    localparam logic [6:0] CtlOmniLow     = 7'd123;
    localparam logic [6:0] CtlPolyOn      = 7'd127;

    localparam logic [7:0] SBit = 8'h80;

    typedef struct packed {
        logic [1:0]  command;
        logic [6:0]  pitch;
        logic [6:0]  pressure;
        logic [15:0] payload_number;
        logic [15:0] checkpoint_number;
        logic [1:0]  reset_kind;
        logic        is_control_change;
        logic [6:0]  controller;
    } t_in_word;

    typedef struct packed {
        logic [7:0] first_note_byte;
        logic [7:0] first_pressure_byte;
        logic       first_valid;
        logic [7:0] second_note_byte;
        logic [7:0] second_pressure_byte;
        logic       second_valid;
        logic [7:0] header_byte;
        logic [8:0] chapter_bytes;
        logic       clear_parent_s;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic ld;
        logic rd_node;
        logic unlink;
        logic append;
        logic clr;
        logic x_mode;
        logic walk_init;
        logic walk_rd;
        logic walk_adv;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic       pitch_present;
        logic       kind_clear;
        logic       x_match;
        logic       count_zero;
        logic       remain_one;
    } t_dp_stat;

endpackage

// ----- hw/rtl/poly_aftertouch_journal_chapter.sv -----
// polyphonic key-pressure journal chapter
// input: one word accepted when start is high and busy is low
//   key pressure: unlinks the pitch if present, appends at the tail
//   reset notice: clears for state/n-active kinds; a mode control
//     change then walks the list setting X
//   build: walks the list head to tail
// output: o_word is valid for exactly one cycle while o_strobe is high
//   one word per two emitted entries; the final word has last set and
//   carries header, byte length and parent-S clear flag
//   an empty build gives a single word with only last set
// the list is linked by pitch through next/prev memories
// the receiver cannot stall; words are never held
// reset: synchronous active low, empties the list; no clearing pass
module poly_aftertouch_journal_chapter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  paj_pkg::t_in_word  i_word,
    output paj_pkg::t_out_word o_word,
    output logic               o_strobe
);

    paj_pkg::t_dp_cmd  cmd;
    paj_pkg::t_dp_stat stat;

    paj_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    paj_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_word   (i_word),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_word   (o_word),
        .o_strobe (o_strobe)
    );

endmodule

// ----- hw/rtl/paj_datapath.sv -----
`include "assert_macros.svh"

module paj_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  paj_pkg::t_in_word  i_word,
    input  paj_pkg::t_dp_cmd   i_cmd,
    output paj_pkg::t_dp_stat  o_stat,
    output paj_pkg::t_out_word o_word,
    output logic               o_strobe
);

    logic [paj_pkg::PitchW-1:0] r_nxt_mem [paj_pkg::MaxNotes];
    logic [paj_pkg::PitchW-1:0] r_prv_mem [paj_pkg::MaxNotes];
    logic [22:0]                r_dat_mem [paj_pkg::MaxNotes];
    logic                       r_x_mem   [paj_pkg::MaxNotes];

    paj_pkg::t_in_word          r_item;
    logic [paj_pkg::MaxNotes-1:0] r_present;
    logic [paj_pkg::CountW-1:0] r_count;
    logic [paj_pkg::CountW-1:0] r_remain;
    logic [paj_pkg::CountW-1:0] r_emitted;
    logic [paj_pkg::PitchW-1:0] r_head;
    logic [paj_pkg::PitchW-1:0] r_tail;
    logic [paj_pkg::PitchW-1:0] r_cur;
    logic [paj_pkg::PitchW-1:0] r_nq;
    logic [paj_pkg::PitchW-1:0] r_pq;
    logic [22:0]                r_dq;
    logic                       r_xq;
    logic                       r_hdr_s;
    logic                       r_clr_s;
    paj_pkg::t_out_word         r_pend;
    paj_pkg::t_out_word         r_out;
    logic                       r_strobe;

    logic [paj_pkg::PitchW-1:0] n_rd_addr;
    logic [15:0]                n_prev;
    logic                       n_take;
    logic                       n_s;
    logic [7:0]                 n_nb;
    logic [7:0]                 n_pb;
    paj_pkg::t_out_word         n_pend;
    paj_pkg::t_out_word         n_out;
    logic                       n_strobe;

    assign n_rd_addr = i_cmd.rd_node ? r_item.pitch : r_cur;
    assign n_prev    = r_item.payload_number - 16'd1;
    assign n_take    = r_dq[15:0] >= r_item.checkpoint_number;
    assign n_s       = r_dq[15:0] != n_prev;
    assign n_nb      = {n_s, r_cur};
    assign n_pb      = {r_xq, r_dq[22:16]};
    assign n_strobe  = i_cmd.fin |
                       (i_cmd.walk_adv & !i_cmd.x_mode & n_take & !r_emitted[0] &
                        (r_emitted != '0));

    always_comb begin
        o_stat.command       = r_item.command;
        o_stat.pitch_present = r_present[r_item.pitch];
        o_stat.kind_clear    = (r_item.reset_kind == paj_pkg::KindState) ||
                               (r_item.reset_kind == paj_pkg::KindNActive);
        o_stat.x_match       = r_item.is_control_change &&
                               ((r_item.controller == paj_pkg::CtlAllSoundOff) ||
                                (r_item.controller >= paj_pkg::CtlOmniLow &&
                                 r_item.controller <= paj_pkg::CtlPolyOn));
        o_stat.count_zero    = r_count == '0;
        o_stat.remain_one    = r_remain == paj_pkg::CountW'(1);
    end

    always_comb begin
        n_pend = r_pend;
        if (!r_emitted[0]) begin
            n_pend                     = '0;
            n_pend.first_note_byte     = n_nb;
            n_pend.first_pressure_byte = n_pb;
            n_pend.first_valid         = 1'b1;
        end else begin
            n_pend.second_note_byte     = n_nb;
            n_pend.second_pressure_byte = n_pb;
            n_pend.second_valid         = 1'b1;
        end
        n_out      = r_pend;
        n_out.last = 1'b1;
        if (r_emitted != '0) begin
            n_out.header_byte    = (r_hdr_s ? paj_pkg::SBit : 8'h00) |
                                   {1'b0, r_emitted[6:0] - 7'd1};
            n_out.chapter_bytes  = {r_emitted, 1'b1};
            n_out.clear_parent_s = r_clr_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_node || i_cmd.walk_rd) begin
            r_nq <= r_nxt_mem[n_rd_addr];
            r_pq <= r_prv_mem[n_rd_addr];
            r_dq <= r_dat_mem[n_rd_addr];
            r_xq <= r_x_mem[n_rd_addr];
        end
        if (i_cmd.unlink && r_head != r_item.pitch) begin
            r_nxt_mem[r_pq] <= r_nq;
        end else if (i_cmd.append && r_count != '0) begin
            r_nxt_mem[r_tail] <= r_item.pitch;
        end
        if (i_cmd.unlink && r_tail != r_item.pitch) begin
            r_prv_mem[r_nq] <= r_pq;
        end else if (i_cmd.append) begin
            r_prv_mem[r_item.pitch] <= r_tail;
        end
        if (i_cmd.append) begin
            r_dat_mem[r_item.pitch] <= {r_item.pressure, r_item.payload_number};
            r_x_mem[r_item.pitch]   <= 1'b0;
        end else if (i_cmd.walk_rd && i_cmd.x_mode) begin
            r_x_mem[r_cur] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_count   <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_strobe <= n_strobe;
            if (i_cmd.ld) begin
                r_item <= i_word;
            end
            if (i_cmd.clr) begin
                r_present <= '0;
                r_count   <= '0;
            end
            if (i_cmd.unlink) begin
                if (r_head == r_item.pitch) begin
                    r_head <= r_nq;
                end
                if (r_tail == r_item.pitch) begin
                    r_tail <= r_pq;
                end
                r_count <= r_count - paj_pkg::CountW'(1);
            end
            if (i_cmd.append) begin
                if (r_count == '0) begin
                    r_head <= r_item.pitch;
                end
                r_tail                  <= r_item.pitch;
                r_present[r_item.pitch] <= 1'b1;
                r_count                 <= r_count + paj_pkg::CountW'(1);
            end
            if (i_cmd.walk_init) begin
                r_cur     <= r_head;
                r_remain  <= r_count;
                r_emitted <= '0;
                r_hdr_s   <= 1'b0;
                r_clr_s   <= 1'b0;
                r_pend    <= '0;
            end
            if (i_cmd.walk_adv) begin
                r_cur    <= r_nq;
                r_remain <= r_remain - paj_pkg::CountW'(1);
                if (!i_cmd.x_mode && n_take) begin
                    r_emitted <= r_emitted + paj_pkg::CountW'(1);
                    r_hdr_s   <= n_s;
                    if (!n_s) begin
                        r_clr_s <= 1'b1;
                    end
                    if (!r_emitted[0] && r_emitted != '0) begin
                        r_out <= r_pend;
                    end
                    r_pend <= n_pend;
                end
            end
            if (i_cmd.fin) begin
                r_out <= n_out;
            end
        end
    end

    assign o_word   = r_out;
    assign o_strobe = r_strobe;

    `PAJ_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= paj_pkg::CountW'(paj_pkg::MaxNotes), "count beyond capacity")
    `PAJ_ASSERT(a_unlink_present, i_clk, i_rst_n, i_cmd.unlink |-> r_present[r_item.pitch], "unlink of absent pitch")

endmodule

// ----- hw/rtl/paj_ctrl.sv -----
`include "assert_macros.svh"

module paj_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  paj_pkg::t_dp_stat i_stat,
    output paj_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_KUNL, S_KAPP, S_WINIT, S_WRD, S_WADV, S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_x_mode;
    logic   n_x_mode;

    always_comb begin
        n_state  = r_state;
        n_x_mode = r_x_mode;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.ld = 1'b1;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.command)
                    paj_pkg::CmdKey: begin
                        if (i_stat.pitch_present) begin
                            o_cmd.rd_node = 1'b1;
                            n_state       = S_KUNL;
                        end else begin
                            n_state = S_KAPP;
                        end
                    end
                    paj_pkg::CmdReset: begin
                        o_cmd.clr = i_stat.kind_clear;
                        n_x_mode  = 1'b1;
                        n_state   = i_stat.x_match ? S_WINIT : S_IDLE;
                    end
                    paj_pkg::CmdBuild: begin
                        n_x_mode = 1'b0;
                        n_state  = S_WINIT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_KUNL: begin
                o_cmd.unlink = 1'b1;
                n_state      = S_KAPP;
            end
            S_KAPP: begin
                o_cmd.append = 1'b1;
                n_state      = S_IDLE;
            end
            S_WINIT: begin
                o_cmd.walk_init = 1'b1;
                if (!i_stat.count_zero) begin
                    n_state = S_WRD;
                end else begin
                    n_state = r_x_mode ? S_IDLE : S_FIN;
                end
            end
            S_WRD: begin
                o_cmd.walk_rd = 1'b1;
                n_state       = S_WADV;
            end
            S_WADV: begin
                o_cmd.walk_adv = 1'b1;
                if (i_stat.remain_one) begin
                    n_state = r_x_mode ? S_IDLE : S_FIN;
                end else begin
                    n_state = S_WRD;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.x_mode = r_x_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_x_mode <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_x_mode <= n_x_mode;
        end
    end

    assign o_busy = r_state != S_IDLE;

    `PAJ_ASSERT(a_accept_disp, i_clk, i_rst_n, (i_start && !o_busy) |=> r_state == S_DISP, "accepted word not dispatched")
    `PAJ_ASSERT(a_unlink_append, i_clk, i_rst_n, r_state == S_KUNL |=> r_state == S_KAPP, "unlink not followed by append")
    `PAJ_ASSERT(a_fin_build, i_clk, i_rst_n, o_cmd.fin |-> !r_x_mode, "header flush outside a build")

endmodule
